[rtl/core/sdaf_pkg.sv]
`timescale 1ns / 1ps
// sdaf_pkg: shared widths, character codes and control struct for the
// signed decimal ascii formatter; depends on nothing
package sdaf_pkg;

    localparam int VALUE_W            = 32;
    localparam int CHAR_W             = 6;
    localparam int DIGIT_W            = 4;
    localparam int DEFAULT_MAX_DIGITS = 10;

    // binary to bcd conversion is split into equal shift-add stages
    localparam int DABBLE_STAGES   = 4;
    localparam int STEPS_PER_STAGE = VALUE_W / DABBLE_STAGES;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHR_MINUS = CHAR_W'(45);
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = DIGIT_W'(3);

    // control that travels beside the data through each pipeline stage
    typedef struct packed {
        logic valid;
        logic neg;
    } sdaf_ctl_t;

    // shift-add-3 correction for one bcd digit
    function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
        add3 = (d >= DIGIT_ADJ_MIN) ? d + DIGIT_ADJ : d;
    endfunction

endpackage

[rtl/core/sdaf_dabble.sv]
`timescale 1ns / 1ps
// sdaf_dabble: one registered stage of the shift-add-3 binary to bcd
// conversion; depends on sdaf_pkg
module sdaf_dabble #(
    parameter int DIGITS = sdaf_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  sdaf_pkg::sdaf_ctl_t               in_ctl,
    input  logic [sdaf_pkg::VALUE_W-1:0]      in_bin,
    input  logic [DIGITS*sdaf_pkg::DIGIT_W-1:0] in_bcd,
    output sdaf_pkg::sdaf_ctl_t               out_ctl,
    output logic [sdaf_pkg::VALUE_W-1:0]      out_bin,
    output logic [DIGITS*sdaf_pkg::DIGIT_W-1:0] out_bcd
);
    import sdaf_pkg::*;

    localparam int BCD_W = DIGITS * DIGIT_W;

    sdaf_ctl_t          ctl_reg;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;

    // a fixed number of correct-then-shift steps
    always_comb
    begin
        logic [VALUE_W-1:0] b;
        logic [BCD_W-1:0]   d;
        b = in_bin;
        d = in_bcd;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                d[k*DIGIT_W +: DIGIT_W] = add3(d[k*DIGIT_W +: DIGIT_W]);
            end
            d = {d[BCD_W-2:0], b[VALUE_W-1]};
            b = {b[VALUE_W-2:0], 1'b0};
        end
        bin_next = b;
        bcd_next = d;
    end

    // stage register, moves only when the next stage can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_bin = bin_reg;
    assign out_bcd = bcd_reg;

endmodule

[rtl/core/sdaf_lead.sv]
`timescale 1ns / 1ps
// sdaf_lead: finds the most significant nonzero bcd digit and registers it
// with the digits; depends on sdaf_pkg
module sdaf_lead #(
    parameter int DIGITS = sdaf_pkg::DEFAULT_MAX_DIGITS,
    parameter int IDX_W  = $clog2(DIGITS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  sdaf_pkg::sdaf_ctl_t                 in_ctl,
    input  logic [DIGITS*sdaf_pkg::DIGIT_W-1:0] in_bcd,
    output sdaf_pkg::sdaf_ctl_t                 out_ctl,
    output logic [DIGITS*sdaf_pkg::DIGIT_W-1:0] out_bcd,
    output logic [IDX_W-1:0]                    out_top
);
    import sdaf_pkg::*;

    localparam int BCD_W = DIGITS * DIGIT_W;

    sdaf_ctl_t        ctl_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [IDX_W-1:0] top_reg, top_next;

    // highest nonzero digit, zero prints as one digit
    always_comb
    begin
        top_next = '0;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (in_bcd[k*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_next = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bcd_reg <= in_bcd;
            top_reg <= top_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_bcd = bcd_reg;
    assign out_top = top_reg;

endmodule

[rtl/core/sdaf_emit.sv]
`timescale 1ns / 1ps
// sdaf_emit: serializes sign and digits into one character beat per cycle
// through a registered output; depends on sdaf_pkg
module sdaf_emit #(
    parameter int DIGITS = sdaf_pkg::DEFAULT_MAX_DIGITS,
    parameter int IDX_W  = $clog2(DIGITS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sdaf_pkg::sdaf_ctl_t                 in_ctl,
    input  logic [DIGITS*sdaf_pkg::DIGIT_W-1:0] in_bcd,
    input  logic [IDX_W-1:0]                    in_top,
    output logic                                free,
    output logic                                strobe,
    output logic [sdaf_pkg::CHAR_W-1:0]         character,
    output logic                                last
);
    import sdaf_pkg::*;

    localparam int BCD_W = DIGITS * DIGIT_W;

    logic              active_reg, active_next;
    logic              neg_pend_reg, neg_pend_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic              strobe_reg, strobe_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              load;

    // free when idle or sending the final digit this cycle
    assign free = !active_reg || (!neg_pend_reg && (idx_reg == '0));
    assign load = in_ctl.valid && free;

    // next character and sequencing
    always_comb
    begin
        active_next   = active_reg;
        neg_pend_next = neg_pend_reg;
        idx_next      = idx_reg;
        bcd_next      = bcd_reg;
        strobe_next   = 1'b0;
        char_next     = char_reg;
        last_next     = 1'b0;
        if (active_reg)
        begin
            strobe_next = 1'b1;
            if (neg_pend_reg)
            begin
                char_next     = CHR_MINUS;
                neg_pend_next = 1'b0;
            end
            else
            begin
                char_next = CHR_ZERO + CHAR_W'(bcd_reg[idx_reg*DIGIT_W +: DIGIT_W]);
                last_next = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
        if (load)
        begin
            active_next   = 1'b1;
            neg_pend_next = in_ctl.neg;
            idx_next      = in_top;
            bcd_next      = in_bcd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            neg_pend_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            neg_pend_reg <= neg_pend_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // a new number is never loaded over one still being sent
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!active_reg || (!neg_pend_reg && idx_reg == '0)))
        else $error("emitter loaded while busy");

    // a minus sign only opens a number
    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && char_reg == CHR_MINUS) |-> !last_reg)
        else $error("minus sign flagged as last");

    // after the sign a digit always follows in the next cycle
    a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && char_reg == CHR_MINUS) |=> (strobe_reg && char_reg != CHR_MINUS))
        else $error("sign not followed by a digit");
`endif

endmodule

[rtl/core/signed_decimal_ascii_formatter.sv]
`timescale 1ns / 1ps
// signed_decimal_ascii_formatter: top level, entry register, bcd pipeline,
// leading digit stage and character emitter; depends on sdaf_pkg and submodules
//
// Usage:
//   A number is taken on value at a rising edge where start is high and busy
//   is low. Its decimal text leaves as character beats: strobe is high for
//   exactly one cycle per character, a minus sign first for negative values,
//   then the digits most significant first without leading zeros; last marks
//   the final character. The receiver cannot stall the output.
//   Path to the ports: the accept edge loads the entry register; the number
//   then passes four shift-add-3 stages, the leading digit stage, the
//   emitter load and the output register before its first character shows.
//   Throughput: the emitter sends one character per cycle; a number is
//   (digits + 1 if negative) characters long, 1 to 11 at 32 bits;
//   numbers queue in the six pipeline stages behind it and busy rises when
//   the entry register cannot move on.
//   Reset clears all valid bits and the output strobe; nothing else is kept.
module signed_decimal_ascii_formatter #(
    parameter int MAX_DIGITS = sdaf_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sdaf_pkg::VALUE_W-1:0] value,
    output logic                               strobe,
    output logic [sdaf_pkg::CHAR_W-1:0]        character,
    output logic                               last
);
    import sdaf_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int IDX_W = $clog2(MAX_DIGITS);

    sdaf_ctl_t          s0_ctl_reg, s0_ctl_next;
    logic [VALUE_W-1:0] s0_mag_reg, s0_mag_next;
    logic               accept;

    sdaf_ctl_t          dab_ctl [DABBLE_STAGES+1];
    logic [VALUE_W-1:0] dab_bin [DABBLE_STAGES+1];
    logic [BCD_W-1:0]   dab_bcd [DABBLE_STAGES+1];
    logic               dab_adv [DABBLE_STAGES];

    sdaf_ctl_t          lead_ctl;
    logic [BCD_W-1:0]   lead_bcd;
    logic [IDX_W-1:0]   lead_top;
    logic               lead_adv;
    logic               emit_free;
    logic               s0_adv;

    // stall chain: a stage moves when empty or when the next one moves
    assign lead_adv = !lead_ctl.valid || emit_free;
    always_comb
    begin
        dab_adv[DABBLE_STAGES-1] = !dab_ctl[DABBLE_STAGES].valid || lead_adv;
        for (int k = DABBLE_STAGES - 2; k >= 0; k--)
        begin
            dab_adv[k] = !dab_ctl[k+1].valid || dab_adv[k+1];
        end
    end
    assign s0_adv = !s0_ctl_reg.valid || dab_adv[0];
    assign busy   = !s0_adv;
    assign accept = start && !busy;

    // entry register: sign and unsigned magnitude
    always_comb
    begin
        s0_ctl_next.valid = accept;
        s0_ctl_next.neg   = value[VALUE_W-1];
        s0_mag_next       = value[VALUE_W-1] ? (~value + 1'b1) : value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else if (s0_adv)
        begin
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv && accept)
        begin
            s0_mag_reg <= s0_mag_next;
        end
    end

    assign dab_ctl[0] = s0_ctl_reg;
    assign dab_bin[0] = s0_mag_reg;
    assign dab_bcd[0] = '0;

    // binary to bcd pipeline
    for (genvar g = 0; g < DABBLE_STAGES; g++)
    begin : g_dabble
        sdaf_dabble #(
            .DIGITS (MAX_DIGITS)
        ) u_dabble (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (dab_adv[g]),
            .in_ctl  (dab_ctl[g]),
            .in_bin  (dab_bin[g]),
            .in_bcd  (dab_bcd[g]),
            .out_ctl (dab_ctl[g+1]),
            .out_bin (dab_bin[g+1]),
            .out_bcd (dab_bcd[g+1])
        );
    end

    // leading digit search
    sdaf_lead #(
        .DIGITS (MAX_DIGITS),
        .IDX_W  (IDX_W)
    ) u_lead (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (lead_adv),
        .in_ctl  (dab_ctl[DABBLE_STAGES]),
        .in_bcd  (dab_bcd[DABBLE_STAGES]),
        .out_ctl (lead_ctl),
        .out_bcd (lead_bcd),
        .out_top (lead_top)
    );

    // character emitter
    sdaf_emit #(
        .DIGITS (MAX_DIGITS),
        .IDX_W  (IDX_W)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (lead_ctl),
        .in_bcd    (lead_bcd),
        .in_top    (lead_top),
        .free      (emit_free),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

`ifndef ASSERT_OFF
    // an accepted number occupies the entry register next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s0_ctl_reg.valid)
        else $error("accepted number lost at entry");

    // busy only when the entry register holds a stalled number
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (s0_ctl_reg.valid && dab_ctl[1].valid))
        else $error("busy without a stalled entry");

    // a stalled entry keeps its magnitude
    a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(s0_mag_reg))
        else $error("stalled entry changed");
`endif

endmodule
